>>> src/flpt_pkg.sv
// Package for the four-level page table mapper: codes, FSM states and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package flpt_pkg;

    localparam int TABLE_SLOTS_DEF = 64;
    localparam int ENT_BITS        = 9;
    localparam int ENTRIES         = 512;
    localparam int PG_OFS_BITS     = 12;
    localparam int MEMO_BITS       = 43;
    localparam int PAGE_CNT_BITS   = 21;

    localparam logic [63:0] VIRT_BASE_RST = 64'h0000_0001_0000_0000;
    localparam logic [63:0] PHYS_BASE_RST = 64'h0000_0002_0000_0000;
    localparam logic [63:0] PAGE_BYTES    = 64'd4096;
    localparam logic [63:0] BIT_P         = 64'd1;
    localparam logic [63:0] BIT_W         = 64'd2;
    localparam logic [63:0] BIT_U         = 64'd4;
    localparam logic [63:0] BIT_NX        = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ADDR_MASK     = ~64'hFFF;

    localparam logic [1:0] RQ_MAP     = 2'd0;
    localparam logic [1:0] RQ_UNMAP   = 2'd1;
    localparam logic [1:0] RQ_PROTECT = 2'd2;
    localparam logic [1:0] RQ_LOOKUP  = 2'd3;

    localparam logic CFG_VIRT_BASE = 1'b0;
    localparam logic CFG_PHYS_BASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REJECT   = 2'd1,
        ST_FULL     = 2'd2,
        ST_UNMAPPED = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_PAGE, S_DIR_RD, S_DIR_WAIT, S_SCAN_RD, S_SCAN_CMP,
        S_CLR, S_LINK, S_MEMO, S_LEAF_RD, S_LEAF_WAIT, S_DONE
    } t_state;

    typedef struct packed {
        logic    req_ready;
        logic    setup;
        logic    walk_start;
        logic    alloc;
        logic    clr_step;
        logic    set_root;
        logic    dir_link;
        logic    dir_rd;
        logic    scan_begin;
        logic    scan_rd;
        logic    scan_cmp;
        logic    memo_set;
        logic    leaf_rd;
        logic    leaf_cap;
        logic    leaf_wr;
        logic    page_next;
        logic    out_load;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        logic req_fire;
        logic reject;
        logic is_map;
        logic is_lookup;
        logic pages_done;
        logic memo_hit;
        logic root_present;
        logic full;
        logic ent_present;
        logic scan_end;
        logic scan_hit;
        logic lv_last;
        logic clr_last;
        logic out_free;
    } t_dp_sts;

endpackage

>>> src/flpt_req_if.sv
// Request channel interface of the page table mapper.
// Depends on nothing.
`timescale 1ns / 1ps
interface flpt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [63:0] start_va;
    logic [31:0] length_bytes;
    logic        perm_write;
    logic        perm_exec;
    logic        at_fixed_va;
    logic        anon_backing;

    modport source(output valid, req_type, start_va, length_bytes, perm_write,
                   perm_exec, at_fixed_va, anon_backing, input ready);
    modport sink(input valid, req_type, start_va, length_bytes, perm_write,
                 perm_exec, at_fixed_va, anon_backing, output ready);
endinterface

>>> src/flpt_rsp_if.sv
// Response channel interface of the page table mapper.
// Depends on nothing.
`timescale 1ns / 1ps
interface flpt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] result_addr;
    logic [63:0] entry_value;

    modport source(output valid, status, result_addr, entry_value, input ready);
    modport sink(input valid, status, result_addr, entry_value, output ready);
endinterface

>>> src/flpt_cfg_if.sv
// Configuration write channel interface of the page table mapper.
// Depends on nothing.
`timescale 1ns / 1ps
interface flpt_cfg_if;
    logic        valid;
    logic        ready;
    logic        reg_index;
    logic [63:0] wdata;

    modport source(output valid, reg_index, wdata, input ready);
    modport sink(input valid, reg_index, wdata, output ready);
endinterface

>>> src/four_level_page_table_mapper_unit.sv
// Top level of the four-level page table mapper: controller plus datapath.
// Depends on flpt_pkg, the channel interfaces, flpt_ctrl and flpt_datapath.
//
//   Channel   Direction  Content
//   i_req     in         req_type, start_va, length_bytes, permission and placement flags
//   o_rsp     out        status, result_addr, entry_value
//   i_cfg     in         reg_index (0 virt_base, 1 phys_base), wdata
//
// One request is handled at a time. A page whose leaf table is cached goes
// straight to the leaf access; an uncached page walks each directory level,
// scanning slot bases for a match. Each new table is cleared entry by entry
// through the single write port of the entry memory, then linked into its
// directory unless it is the root. Reset is synchronous and leaves no table
// allocated. A waiting response does not stop the next request from being
// accepted, but that request holds in its final state until the response is taken.
`timescale 1ns / 1ps
module four_level_page_table_mapper_unit #(
    parameter int TABLE_SLOTS = flpt_pkg::TABLE_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    flpt_req_if.sink   i_req,
    flpt_rsp_if.source o_rsp,
    flpt_cfg_if.sink   i_cfg
);
    import flpt_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    flpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    flpt_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cfg   (i_cfg),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

>>> src/flpt_ctrl.sv
// Controller state machine of the page table mapper: sequences the walk,
// table allocation and leaf updates. Depends on flpt_pkg.
`timescale 1ns / 1ps
module flpt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  flpt_pkg::t_dp_sts i_sts,
    output flpt_pkg::t_dp_cmd o_cmd
);
    import flpt_pkg::*;

    t_state  r_state, n_state;
    t_status r_code, n_code;
    logic    r_ret_root, n_ret_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_code     <= ST_OK;
            r_ret_root <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_code     <= n_code;
            r_ret_root <= n_ret_root;
        end
    end

    // Next state. A missing entry on a walk either ends the request, skips
    // the page, or allocates a new table.
    always_comb begin
        n_state    = r_state;
        n_code     = r_code;
        n_ret_root = r_ret_root;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.req_fire) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.reject) begin
                    n_code  = ST_REJECT;
                    n_state = S_DONE;
                end else begin
                    n_code  = ST_OK;
                    n_state = S_PAGE;
                end
            end
            S_PAGE: begin
                if (i_sts.pages_done && !i_sts.is_lookup) begin
                    n_state = S_DONE;
                end else if (i_sts.memo_hit) begin
                    n_state = S_LEAF_RD;
                end else if (i_sts.root_present) begin
                    n_state = S_DIR_RD;
                end else if (!i_sts.is_map) begin
                    if (i_sts.is_lookup) begin
                        n_code  = ST_UNMAPPED;
                        n_state = S_DONE;
                    end
                end else if (i_sts.full) begin
                    n_code  = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    n_ret_root = 1'b1;
                    n_state    = S_CLR;
                end
            end
            S_DIR_RD: n_state = S_DIR_WAIT;
            S_DIR_WAIT, S_SCAN_RD: begin
                if (r_state == S_DIR_WAIT && i_sts.ent_present) begin
                    n_state = S_SCAN_RD;
                end else if (r_state == S_SCAN_RD && !i_sts.scan_end) begin
                    n_state = S_SCAN_CMP;
                end else if (!i_sts.is_map) begin
                    if (i_sts.is_lookup) begin
                        n_code  = ST_UNMAPPED;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_PAGE;
                    end
                end else if (i_sts.full) begin
                    n_code  = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    n_ret_root = 1'b0;
                    n_state    = S_CLR;
                end
            end
            S_SCAN_CMP: begin
                if (!i_sts.scan_hit)     n_state = S_SCAN_RD;
                else if (i_sts.lv_last)  n_state = S_MEMO;
                else                     n_state = S_DIR_RD;
            end
            S_CLR: begin
                if (i_sts.clr_last) n_state = r_ret_root ? S_DIR_RD : S_LINK;
            end
            S_LINK:    n_state = i_sts.lv_last ? S_MEMO : S_DIR_RD;
            S_MEMO:    n_state = S_LEAF_RD;
            S_LEAF_RD: n_state = S_LEAF_WAIT;
            S_LEAF_WAIT: begin
                if (i_sts.is_lookup) begin
                    n_code  = i_sts.ent_present ? ST_OK : ST_UNMAPPED;
                    n_state = S_DONE;
                end else begin
                    n_state = S_PAGE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd      = '0;
        o_cmd.code = r_code;
        unique case (r_state)
            S_IDLE:  o_cmd.req_ready = 1'b1;
            S_CHECK: o_cmd.setup = !i_sts.reject;
            S_PAGE: begin
                if (!(i_sts.pages_done && !i_sts.is_lookup)) begin
                    if (i_sts.memo_hit || i_sts.root_present) begin
                        o_cmd.walk_start = 1'b1;
                    end else if (!i_sts.is_map) begin
                        o_cmd.page_next = !i_sts.is_lookup;
                    end else if (!i_sts.full) begin
                        o_cmd.alloc = 1'b1;
                    end
                end
            end
            S_DIR_RD: o_cmd.dir_rd = 1'b1;
            S_DIR_WAIT, S_SCAN_RD: begin
                if (r_state == S_DIR_WAIT && i_sts.ent_present) begin
                    o_cmd.scan_begin = 1'b1;
                end else if (r_state == S_SCAN_RD && !i_sts.scan_end) begin
                    o_cmd.scan_rd = 1'b1;
                end else if (!i_sts.is_map) begin
                    o_cmd.page_next = !i_sts.is_lookup;
                end else if (!i_sts.full) begin
                    o_cmd.alloc = 1'b1;
                end
            end
            S_SCAN_CMP: o_cmd.scan_cmp = 1'b1;
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                o_cmd.set_root = i_sts.clr_last && r_ret_root;
            end
            S_LINK:    o_cmd.dir_link = 1'b1;
            S_MEMO:    o_cmd.memo_set = 1'b1;
            S_LEAF_RD: o_cmd.leaf_rd = 1'b1;
            S_LEAF_WAIT: begin
                o_cmd.leaf_cap  = i_sts.is_lookup;
                o_cmd.leaf_wr   = !i_sts.is_lookup;
                o_cmd.page_next = !i_sts.is_lookup;
            end
            S_DONE:  o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> src/flpt_datapath.sv
// Datapath of the page table mapper: request and allocator registers, the
// table entry memory, the slot base memory and the response register.
// Depends on flpt_pkg and the channel interfaces.
`timescale 1ns / 1ps
module flpt_datapath #(
    parameter int TABLE_SLOTS = flpt_pkg::TABLE_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    flpt_req_if.sink          i_req,
    flpt_rsp_if.source        o_rsp,
    flpt_cfg_if.sink          i_cfg,
    input  flpt_pkg::t_dp_cmd i_cmd,
    output flpt_pkg::t_dp_sts o_sts
);
    import flpt_pkg::*;

    localparam int SW    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int UW    = $clog2(TABLE_SLOTS + 1);
    localparam int AW    = SW + ENT_BITS;
    localparam int DEPTH = TABLE_SLOTS * ENTRIES;

    // Latched request.
    logic [1:0]  r_type;
    logic [63:0] r_va;
    logic [31:0] r_len;
    logic        r_pw, r_pe, r_fixed, r_anon;

    logic [PAGE_CNT_BITS-1:0] r_pages, r_pcnt;
    logic [63:0] r_va_cur, r_phys_cur;
    logic [63:0] r_nfv, r_npp;
    logic        r_root;
    logic [UW-1:0] r_used;
    logic        r_memo_v;
    logic [MEMO_BITS-1:0] r_memo_key;
    logic [SW-1:0] r_memo_slot;
    logic [SW-1:0] r_cur, r_new;
    logic [1:0]  r_lv;
    logic [UW-1:0] r_scan;
    logic [ENT_BITS-1:0] r_clr;
    logic [63:0] r_link;
    logic [63:0] r_res_addr, r_res_ent;
    logic        r_o_valid;
    t_status     r_o_status;
    logic [63:0] r_o_addr, r_o_ent;

    logic [63:0] r_ent_mem [DEPTH];
    logic [63:0] r_base_mem [TABLE_SLOTS];
    logic [63:0] r_ent_q, r_base_q;

    logic        req_fire, is_map, is_lookup, memo_hit, full;
    logic [32:0] len_round;
    logic [PAGE_CNT_BITS-1:0] pages;
    logic [63:0] span, target, flags, leaf_val;
    logic [ENT_BITS-1:0] dir_idx;
    logic        ent_we, ent_re;
    logic [AW-1:0] ent_wa, ent_ra;
    logic [63:0] ent_wd;

    assign req_fire  = i_req.valid && i_cmd.req_ready;
    assign is_map    = (r_type == RQ_MAP);
    assign is_lookup = (r_type == RQ_LOOKUP);
    assign memo_hit  = r_memo_v && (r_memo_key == r_va_cur[63:21]);
    assign full      = (r_used == UW'(TABLE_SLOTS));

    assign len_round = {1'b0, r_len} + 33'd4095;
    assign pages     = len_round[32:PG_OFS_BITS];
    assign span      = {{(64-PAGE_CNT_BITS-PG_OFS_BITS){1'b0}}, pages, 12'd0};
    assign target    = r_fixed ? r_va : r_nfv;

    assign flags = BIT_P | BIT_U | (r_pw ? BIT_W : 64'd0) | (r_pe ? 64'd0 : BIT_NX);

    always_comb begin
        unique case (r_lv)
            2'd0:    dir_idx = r_va_cur[47:39];
            2'd1:    dir_idx = r_va_cur[38:30];
            default: dir_idx = r_va_cur[29:21];
        endcase
    end

    always_comb begin
        unique case (r_type)
            RQ_MAP:   leaf_val = r_phys_cur | flags;
            RQ_UNMAP: leaf_val = 64'd0;
            default:  leaf_val = (r_ent_q & ADDR_MASK & ~BIT_NX) | flags;
        endcase
    end

    // One write port: table clearing, directory linking or a leaf update.
    always_comb begin
        ent_we = 1'b0;
        ent_wa = {r_cur, r_va_cur[20:12]};
        ent_wd = leaf_val;
        if (i_cmd.clr_step) begin
            ent_we = 1'b1;
            ent_wa = {r_new, r_clr};
            ent_wd = 64'd0;
        end else if (i_cmd.dir_link) begin
            ent_we = 1'b1;
            ent_wa = {r_cur, dir_idx};
            ent_wd = r_link | BIT_P | BIT_W | BIT_U;
        end else if (i_cmd.leaf_wr) begin
            // A protect request leaves non-present leaves alone.
            ent_we = (r_type != RQ_PROTECT) || r_ent_q[0];
        end
        ent_re = i_cmd.dir_rd || i_cmd.leaf_rd;
        ent_ra = i_cmd.dir_rd ? {r_cur, dir_idx} : {r_cur, r_va_cur[20:12]};
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) r_ent_mem[ent_wa] <= ent_wd;
        if (ent_re) r_ent_q <= r_ent_mem[ent_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc) r_base_mem[r_used[SW-1:0]] <= r_npp;
        if (i_cmd.scan_rd) r_base_q <= r_base_mem[r_scan[SW-1:0]];
    end

    // Control state and allocators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nfv     <= VIRT_BASE_RST;
            r_npp     <= PHYS_BASE_RST;
            r_root    <= 1'b0;
            r_used    <= '0;
            r_memo_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.reg_index == CFG_VIRT_BASE) r_nfv <= i_cfg.wdata;
                else                                  r_npp <= i_cfg.wdata;
            end
            if (i_cmd.setup && is_map) begin
                if (!r_fixed) r_nfv <= r_nfv + span;
                if (r_anon)   r_npp <= r_npp + span;
            end
            if (i_cmd.alloc) begin
                r_npp    <= r_npp + PAGE_BYTES;
                r_used   <= r_used + UW'(1);
                r_memo_v <= 1'b0;
            end
            if (i_cmd.set_root) r_root <= 1'b1;
            if (i_cmd.memo_set) r_memo_v <= 1'b1;
            if (i_cmd.out_load)   r_o_valid <= 1'b1;
            else if (o_rsp.ready) r_o_valid <= 1'b0;
        end
    end

    // Walk and payload registers.
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_type     <= i_req.req_type;
            r_va       <= i_req.start_va;
            r_len      <= i_req.length_bytes;
            r_pw       <= i_req.perm_write;
            r_pe       <= i_req.perm_exec;
            r_fixed    <= i_req.at_fixed_va;
            r_anon     <= i_req.anon_backing;
            r_res_addr <= 64'd0;
            r_res_ent  <= 64'd0;
        end
        if (i_cmd.setup) begin
            r_pages    <= pages;
            r_pcnt     <= '0;
            r_va_cur   <= is_map ? target : r_va;
            r_phys_cur <= (is_map && r_anon) ? r_npp : 64'd0;
            if (is_map) r_res_addr <= target;
        end
        if (i_cmd.walk_start) begin
            r_lv  <= 2'd0;
            r_cur <= memo_hit ? r_memo_slot : '0;
        end
        if (i_cmd.alloc) begin
            r_new  <= r_used[SW-1:0];
            r_link <= r_npp;
            r_clr  <= '0;
        end
        if (i_cmd.clr_step) r_clr <= r_clr + ENT_BITS'(1);
        if (i_cmd.set_root) begin
            r_cur <= '0;
            r_lv  <= 2'd0;
        end
        if (i_cmd.dir_link) begin
            r_cur <= r_new;
            r_lv  <= r_lv + 2'd1;
        end
        if (i_cmd.scan_begin) r_scan <= '0;
        if (i_cmd.scan_cmp) begin
            if (r_base_q[63:12] == r_ent_q[63:12]) begin
                r_cur <= r_scan[SW-1:0];
                r_lv  <= r_lv + 2'd1;
            end else begin
                r_scan <= r_scan + UW'(1);
            end
        end
        if (i_cmd.memo_set) begin
            r_memo_key  <= r_va_cur[63:21];
            r_memo_slot <= r_cur;
        end
        if (i_cmd.leaf_cap) r_res_ent <= r_ent_q;
        if (i_cmd.page_next) begin
            r_pcnt     <= r_pcnt + PAGE_CNT_BITS'(1);
            r_va_cur   <= r_va_cur + PAGE_BYTES;
            r_phys_cur <= r_phys_cur + PAGE_BYTES;
        end
        if (i_cmd.out_load) begin
            r_o_status <= i_cmd.code;
            r_o_addr   <= r_res_addr;
            r_o_ent    <= r_res_ent;
        end
    end

    assign i_req.ready = i_cmd.req_ready;
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.result_addr = r_o_addr;
    assign o_rsp.entry_value = r_o_ent;

    always_comb begin
        o_sts.req_fire     = req_fire;
        o_sts.reject       = !is_lookup && ((r_len == 32'd0) ||
                             ((r_fixed || !is_map) && (r_va[11:0] != 12'd0)));
        o_sts.is_map       = is_map;
        o_sts.is_lookup    = is_lookup;
        o_sts.pages_done   = (r_pcnt == r_pages);
        o_sts.memo_hit     = memo_hit;
        o_sts.root_present = r_root;
        o_sts.full         = full;
        o_sts.ent_present  = r_ent_q[0];
        o_sts.scan_end     = (r_scan == r_used);
        o_sts.scan_hit     = (r_base_q[63:12] == r_ent_q[63:12]);
        o_sts.lv_last      = (r_lv == 2'd2);
        o_sts.clr_last     = (r_clr == ENT_BITS'(ENTRIES - 1));
        o_sts.out_free     = !r_o_valid || o_rsp.ready;
    end

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for four_level_page_table_mapper_unit: a queue-fed driver,
// a response monitor and a page table predictor with its own table store.
// Depends on flpt_pkg, the three channel interfaces and the mapper RTL.
`timescale 1ns / 1ps
module tb_top;
    import flpt_pkg::*;

    localparam int NSLOTS      = TABLE_SLOTS_DEF;
    localparam int CYCLE_LIMIT = 50_000_000;

    typedef struct {
        logic [1:0]  kind;
        logic [63:0] va;
        logic [31:0] len;
        logic        wr;
        logic        ex;
        logic        fixed;
        logic        anon;
    } t_tb_req;

    typedef struct {
        t_status     status;
        logic [63:0] addr;
        logic [63:0] entry;
    } t_tb_rsp;

    logic i_clk;
    logic i_rst_n;

    flpt_req_if req_ch();
    flpt_rsp_if rsp_ch();
    flpt_cfg_if cfg_ch();

    four_level_page_table_mapper_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Predictor state of the page table walker.
    logic [63:0] pt_mem [0:NSLOTS*ENTRIES-1];
    logic [63:0] slot_base [0:NSLOTS-1];
    int          slots_used;
    bit          root_ok;
    logic [63:0] free_virt;
    logic [63:0] free_phys;

    t_tb_req pending_reqs[$];
    t_tb_rsp expected_rsps[$];

    int   fail_count;
    int   send_idle_pct;
    int   stall_pct;
    int   cfg_count;
    int   hold_asks;
    int   hold_seen;
    int   hold_left;
    int   cycles;
    bit   req_taken;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        fail_count++;
    endtask

    function automatic bit alloc_table(output int slot);
        int i;
        if (slots_used >= NSLOTS) return 0;
        slot = slots_used++;
        slot_base[slot] = free_phys;
        free_phys += PAGE_BYTES;
        for (i = 0; i < ENTRIES; i++) pt_mem[slot*ENTRIES + i] = '0;
        return 1;
    endfunction

    function automatic bit find_slot(input logic [63:0] ent, output int slot);
        int s;
        for (s = 0; s < slots_used; s++) begin
            if ((slot_base[s] & ADDR_MASK) == (ent & ADDR_MASK)) begin
                slot = s;
                return 1;
            end
        end
        return 0;
    endfunction

    // Returns the status of the walk; leaf is the entry index when it is ST_OK.
    function automatic t_status walk_to_leaf(input logic [63:0] va, input bit create,
                                             output int leaf);
        int cur, nxt, lv, idx;
        logic [63:0] ent;
        if (!root_ok) begin
            if (!create) return ST_UNMAPPED;
            if (!alloc_table(cur)) return ST_FULL;
            root_ok = 1;
        end
        cur = 0;
        for (lv = 0; lv < 3; lv++) begin
            idx = cur*ENTRIES + int'((va >> (39 - 9*lv)) & 64'h1FF);
            ent = pt_mem[idx];
            if (ent[0] && find_slot(ent, nxt)) begin
                cur = nxt;
            end else begin
                if (!create) return ST_UNMAPPED;
                if (!alloc_table(nxt)) return ST_FULL;
                pt_mem[idx] = slot_base[nxt] | BIT_P | BIT_W | BIT_U;
                cur = nxt;
            end
        end
        leaf = cur*ENTRIES + int'((va >> 12) & 64'h1FF);
        return ST_OK;
    endfunction

    function automatic t_tb_rsp apply_request(input t_tb_req r);
        t_tb_rsp     o;
        logic [63:0] pages, flags, target, phys, p;
        int          leaf;
        t_status     st;
        o = '{ST_OK, '0, '0};
        pages = ({32'h0, r.len} + 64'd4095) >> 12;
        flags = BIT_P | BIT_U | (r.wr ? BIT_W : 64'h0) | (r.ex ? 64'h0 : BIT_NX);
        if (r.kind == RQ_LOOKUP) begin
            if (walk_to_leaf(r.va, 0, leaf) != ST_OK) begin
                o.status = ST_UNMAPPED;
            end else begin
                o.entry  = pt_mem[leaf];
                o.status = pt_mem[leaf][0] ? ST_OK : ST_UNMAPPED;
            end
            return o;
        end
        if (r.kind == RQ_MAP) begin
            if (r.len == 0 || (r.fixed && r.va[11:0] != 0)) begin
                o.status = ST_REJECT;
                return o;
            end
            if (r.fixed) begin
                target = r.va;
            end else begin
                target = free_virt;
                free_virt += pages * PAGE_BYTES;
            end
            phys = '0;
            if (r.anon) begin
                phys = free_phys;
                free_phys += pages * PAGE_BYTES;
            end
            o.addr = target;
            for (p = 0; p < pages; p++) begin
                st = walk_to_leaf(target + p * PAGE_BYTES, 1, leaf);
                if (st != ST_OK) begin
                    o.status = st;
                    return o;
                end
                pt_mem[leaf] = (phys + p * PAGE_BYTES) | flags;
            end
            return o;
        end
        if (r.va[11:0] != 0 || r.len == 0) begin
            o.status = ST_REJECT;
            return o;
        end
        for (p = 0; p < pages; p++) begin
            if (walk_to_leaf(r.va + p * PAGE_BYTES, 0, leaf) != ST_OK) continue;
            if (r.kind == RQ_UNMAP) pt_mem[leaf] = '0;
            else if (pt_mem[leaf][0])
                pt_mem[leaf] = (pt_mem[leaf] & ADDR_MASK & ~BIT_NX) | flags;
        end
        return o;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Monitor: checks responses, then feeds accepted requests and register writes
    // into the predictor.
    always @(posedge i_clk) begin
        t_tb_rsp want;
        t_tb_req r;
        req_taken = i_rst_n && req_ch.valid && req_ch.ready;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsps.size() == 0) begin
                    report("unexpected response status", 64'(rsp_ch.status), '0);
                end else begin
                    want = expected_rsps.pop_front();
                    if (rsp_ch.status !== want.status)
                        report("status", 64'(rsp_ch.status), 64'(want.status));
                    if (rsp_ch.result_addr !== want.addr)
                        report("result_addr", rsp_ch.result_addr, want.addr);
                    if (rsp_ch.entry_value !== want.entry)
                        report("entry_value", rsp_ch.entry_value, want.entry);
                end
            end
            if (req_taken) begin
                r = '{req_ch.req_type, req_ch.start_va, req_ch.length_bytes,
                      req_ch.perm_write, req_ch.perm_exec, req_ch.at_fixed_va,
                      req_ch.anon_backing};
                expected_rsps.push_back(apply_request(r));
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.reg_index == CFG_VIRT_BASE) free_virt = cfg_ch.wdata;
                else free_phys = cfg_ch.wdata;
                cfg_count++;
            end
        end
    end

    // Request driver.
    always @(negedge i_clk) begin
        t_tb_req it;
        if (i_rst_n && (!req_ch.valid || req_taken)) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                it = pending_reqs.pop_front();
                req_ch.req_type     <= it.kind;
                req_ch.start_va     <= it.va;
                req_ch.length_bytes <= it.len;
                req_ch.perm_write   <= it.wr;
                req_ch.perm_exec    <= it.ex;
                req_ch.at_fixed_va  <= it.fixed;
                req_ch.anon_backing <= it.anon;
                req_ch.valid        <= 1'b1;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= 600;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge i_clk)
        rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);

    task automatic cfg_write(input logic idx, input logic [63:0] val);
        int seen;
        seen = cfg_count;
        @(negedge i_clk);
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= val;
        cfg_ch.valid     <= 1'b1;
        do @(negedge i_clk); while (cfg_count == seen);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic queue_req(input logic [1:0] k, input logic [63:0] va,
                             input logic [31:0] len, input logic wr, input logic ex,
                             input logic fx, input logic an);
        pending_reqs.push_back('{k, va, len, wr, ex, fx, an});
    endtask

    function automatic logic [63:0] region_addr();
        logic [63:0] bases [8];
        logic [63:0] va;
        bases = '{64'h0000_0001_0000_0000, 64'h0000_0000_0000_0000,
                  64'h0000_7FFF_FFE0_0000, 64'hFFFF_8000_0000_0000,
                  64'hFFFF_FFFF_FFE0_0000, 64'h0000_0040_0020_0000,
                  64'h1234_5678_9AA0_0000, 64'h0000_0002_0000_0000};
        va = bases[$urandom_range(7)] + (64'($urandom_range(511)) << 12);
        if ($urandom_range(9) == 0) va[11:0] = 12'($urandom);
        return va;
    endfunction

    task automatic queue_random(input int n);
        int i, pick;
        logic [1:0]  k;
        logic [63:0] va;
        logic [31:0] len;
        for (i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            k = pick < 40 ? RQ_MAP : pick < 55 ? RQ_UNMAP : pick < 70 ? RQ_PROTECT : RQ_LOOKUP;
            va = region_addr();
            pick = $urandom_range(99);
            if (k == RQ_LOOKUP) begin
                len = $urandom;
                if (pick < 30) va = {$urandom, $urandom};
            end else if (pick < 5) begin
                len = '0;
            end else if (pick < 10) begin
                // Huge range, only sent where the block rejects it up front.
                len = 32'hFFFF_FFFF;
                va[11:0] = 12'h801;
                if (k == RQ_MAP) begin
                    queue_req(k, va, len, 1'($urandom), 1'($urandom), 1'b1,
                              1'($urandom));
                    continue;
                end
            end else begin
                len = 32'($urandom_range(16, 1)) * 4096 - 32'($urandom_range(4095));
            end
            queue_req(k, va, len, 1'($urandom), 1'($urandom), 1'($urandom),
                      1'($urandom));
        end
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 48; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 48; end
            default: begin send_idle_pct = 36; stall_pct = 36; end
        endcase
    endtask

    initial begin
        int i;
        fail_count    = 0;
        cfg_count     = 0;
        hold_asks     = 0;
        hold_seen     = 0;
        hold_left     = 0;
        cycles        = 0;
        req_taken     = 0;
        slots_used    = 0;
        root_ok       = 0;
        free_virt     = VIRT_BASE_RST;
        free_phys     = PHYS_BASE_RST;
        send_idle_pct = 0;
        stall_pct     = 0;
        req_ch.valid = 0;
        req_ch.req_type = RQ_MAP;
        req_ch.start_va = '0;
        req_ch.length_bytes = '0;
        req_ch.perm_write = 0;
        req_ch.perm_exec = 0;
        req_ch.at_fixed_va = 0;
        req_ch.anon_backing = 0;
        rsp_ch.ready = 0;
        cfg_ch.valid = 0;
        cfg_ch.reg_index = CFG_VIRT_BASE;
        cfg_ch.wdata = '0;
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed part on the reset register values.
        queue_req(RQ_LOOKUP, 64'h0000_0001_0000_0000, 32'hFFFF_FFFF, 1, 1, 1, 1);
        queue_req(RQ_MAP, 64'h0000_0000_0000_0123, 32'd4096, 1, 1, 0, 1);
        queue_req(RQ_LOOKUP, 64'h0000_0001_0000_0000, 32'd0, 0, 0, 0, 0);
        queue_req(RQ_PROTECT, 64'h0000_0001_0000_0000, 32'd1, 0, 0, 0, 0);
        queue_req(RQ_LOOKUP, 64'h0000_0001_0000_0000, 32'd0, 0, 0, 0, 0);
        queue_req(RQ_UNMAP, 64'h0000_0001_0000_0000, 32'd4096, 0, 0, 0, 0);
        queue_req(RQ_LOOKUP, 64'h0000_0001_0000_0000, 32'd0, 0, 0, 0, 0);
        queue_req(RQ_PROTECT, 64'h0000_0001_0000_0000, 32'd4096, 1, 1, 0, 0);
        queue_req(RQ_MAP, 64'h0, 32'd0, 1, 1, 0, 1);
        queue_req(RQ_MAP, 64'h0000_0003_0000_0800, 32'hFFFF_FFFF, 1, 1, 1, 1);
        queue_req(RQ_UNMAP, 64'h0000_0001_0000_0010, 32'd4096, 0, 0, 0, 0);
        queue_req(RQ_UNMAP, 64'h0000_0001_0000_0000, 32'd0, 0, 0, 0, 0);
        queue_req(RQ_PROTECT, 64'h0000_0001_0000_0004, 32'd4096, 0, 0, 0, 0);
        // Fixed map that wraps past the top of the address space, from physical zero.
        queue_req(RQ_MAP, 64'hFFFF_FFFF_FFFF_F000, 32'd8192, 0, 0, 1, 0);
        queue_req(RQ_LOOKUP, 64'hFFFF_FFFF_FFFF_F000, 32'd0, 0, 0, 0, 0);
        queue_req(RQ_LOOKUP, 64'h0000_0000_0000_0FFF, 32'd0, 0, 0, 0, 0);
        queue_req(RQ_MAP, 64'h0000_0001_0000_0000, 32'd12289, 1, 0, 1, 1);
        queue_req(RQ_PROTECT, 64'h0000_0001_0000_0000, 32'd16384, 1, 1, 0, 0);
        queue_req(RQ_LOOKUP, 64'h0000_0001_0000_2000, 32'd0, 0, 0, 0, 0);
        queue_req(RQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 1);
        queue_random(180);
        wait_drained();

        for (i = 1; i <= 4; i++) begin
            case (i)
                1: begin cfg_write(CFG_VIRT_BASE, '0); cfg_write(CFG_PHYS_BASE, '0); end
                2: begin
                    cfg_write(CFG_VIRT_BASE, '1);
                    cfg_write(CFG_PHYS_BASE, 64'h0000_0003_0000_0123);
                end
                3: begin
                    cfg_write(CFG_VIRT_BASE, {$urandom, $urandom});
                    cfg_write(CFG_PHYS_BASE, '1);
                end
                default: begin
                    cfg_write(CFG_VIRT_BASE, {$urandom, $urandom} & ADDR_MASK);
                    cfg_write(CFG_PHYS_BASE, {$urandom, $urandom});
                end
            endcase
            set_idling(i);
            queue_random(200);
            // Hold the response side off for a while so the block backs up.
            if (i == 2) hold_asks++;
            wait_drained();
        end

        // Scatter one-page maps until the table store runs out, then keep going.
        set_idling(0);
        cfg_write(CFG_PHYS_BASE, 64'h0000_0008_0000_0000);
        for (i = 0; i < 40; i++)
            queue_req(RQ_MAP, {$urandom, $urandom} & 64'h0000_FFFF_FFFF_F000, 32'd4096,
                      1'($urandom), 1'($urandom), 1'b1, 1'($urandom));
        queue_req(RQ_MAP, 64'h0, 32'hFFFF_FFFF, 1, 1, 0, 1);
        queue_random(180);
        wait_drained();

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
